FILE: src/pbpid_pkg.sv
// Shared types, widths and constants of the proportional-band PID step.
package pbpid_pkg;

  typedef logic signed [15:0] meas_t;
  typedef logic        [15:0] dt_t;
  typedef logic signed [31:0] gain_t;
  typedef logic        [31:0] limit_t;
  typedef logic signed [16:0] err_t;
  typedef logic signed [32:0] int_t;
  typedef logic signed [33:0] isum_t;
  typedef logic signed [32:0] mul_t;
  typedef logic signed [65:0] prod_t;
  typedef logic signed [49:0] p_t;
  typedef logic signed [61:0] i_t;
  typedef logic signed [48:0] d_t;
  typedef logic signed [62:0] acc_t;
  typedef logic        [47:0] mag_t;
  typedef logic        [15:0] rem_t;
  typedef logic        [16:0] rem_ext_t;
  typedef logic        [5:0]  div_cnt_t;
  typedef logic        [2:0]  cfg_index_t;
  typedef logic        [31:0] cfg_data_t;

  localparam cfg_index_t REG_GAIN_P         = 3'd0;
  localparam cfg_index_t REG_GAIN_I         = 3'd1;
  localparam cfg_index_t REG_GAIN_D         = 3'd2;
  localparam cfg_index_t REG_INTEGRAL_LIMIT = 3'd3;
  localparam cfg_index_t REG_TARGET         = 3'd4;

  localparam meas_t    LAST_RESET  = 16'sd2400;
  localparam limit_t   LIMIT_RESET = 32'hFFFF_FFFF;
  localparam p_t       P_OFFSET    = p_t'((64'sd1 <<< 27) + (64'sd1 <<< 11));
  localparam prod_t    TERM_LIMIT  = prod_t'(1) <<< 60;
  localparam acc_t     DRIVE_MAX   = acc_t'(64'sh7FFF_FFFF);
  localparam acc_t     DRIVE_MIN   = -(acc_t'(1) <<< 31);
  localparam div_cnt_t DIV_LAST    = 6'd47;

  typedef struct packed {
    logic signed [15:0] measurement;
    logic        [15:0] elapsed_seconds;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] drive;
    logic               saturated;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LOAD,
    OP_MUL_P,
    OP_MUL_E,
    OP_ADD_E,
    OP_CLAMP,
    OP_MUL_I,
    OP_MUL_D,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_FIX,
    OP_SUM_PI,
    OP_SUM_D,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    logic dt_zero;
    logic div_last;
  } dp_status_t;

endpackage

FILE: src/pbpid_ctrl.sv
// Sequencing state machine of the PID step: issues one datapath command per cycle.
module pbpid_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  pbpid_pkg::dp_status_t status,
  output pbpid_pkg::dp_op_t     op
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_P,
    ST_MUL_E,
    ST_ADD_E,
    ST_CLAMP,
    ST_MUL_I,
    ST_MUL_D,
    ST_DIV_INIT,
    ST_DIV,
    ST_DIV_FIX,
    ST_SUM_PI,
    ST_SUM_D,
    ST_OUT
  } state_t;

  state_t state;
  logic   out_free;

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    unique case (state)
      ST_IDLE:     op = in_valid ? pbpid_pkg::OP_LOAD : pbpid_pkg::OP_IDLE;
      ST_MUL_P:    op = pbpid_pkg::OP_MUL_P;
      ST_MUL_E:    op = pbpid_pkg::OP_MUL_E;
      ST_ADD_E:    op = pbpid_pkg::OP_ADD_E;
      ST_CLAMP:    op = pbpid_pkg::OP_CLAMP;
      ST_MUL_I:    op = pbpid_pkg::OP_MUL_I;
      ST_MUL_D:    op = pbpid_pkg::OP_MUL_D;
      ST_DIV_INIT: op = pbpid_pkg::OP_DIV_INIT;
      ST_DIV:      op = pbpid_pkg::OP_DIV_STEP;
      ST_DIV_FIX:  op = pbpid_pkg::OP_DIV_FIX;
      ST_SUM_PI:   op = pbpid_pkg::OP_SUM_PI;
      ST_SUM_D:    op = pbpid_pkg::OP_SUM_D;
      ST_OUT:      op = out_free ? pbpid_pkg::OP_OUT : pbpid_pkg::OP_IDLE;
      default:     op = pbpid_pkg::OP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_MUL_P;
          end
        end
        ST_MUL_P:    state <= ST_MUL_E;
        ST_MUL_E:    state <= ST_ADD_E;
        ST_ADD_E:    state <= ST_CLAMP;
        ST_CLAMP:    state <= ST_MUL_I;
        ST_MUL_I:    state <= ST_MUL_D;
        ST_MUL_D:    state <= ST_DIV_INIT;
        ST_DIV_INIT: state <= status.dt_zero ? ST_SUM_PI : ST_DIV;
        ST_DIV: begin
          if (status.div_last) begin
            state <= ST_DIV_FIX;
          end
        end
        ST_DIV_FIX:  state <= ST_SUM_PI;
        ST_SUM_PI:   state <= ST_SUM_D;
        ST_SUM_D:    state <= ST_OUT;
        ST_OUT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default:     state <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: src/pbpid_datapath.sv
// Datapath of the PID step: configuration registers, shared multiplier, divider and output.
module pbpid_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  pbpid_pkg::dp_op_t     op,
  output pbpid_pkg::dp_status_t status,
  input  pbpid_pkg::in_item_t   in_data,
  output pbpid_pkg::out_item_t  out_data,
  input  logic                  cfg_write,
  input  pbpid_pkg::cfg_index_t cfg_index,
  input  pbpid_pkg::cfg_data_t  cfg_data
);

  pbpid_pkg::gain_t    gain_p;
  pbpid_pkg::gain_t    gain_i;
  pbpid_pkg::gain_t    gain_d;
  pbpid_pkg::limit_t   integral_limit;
  pbpid_pkg::meas_t    target;
  pbpid_pkg::int_t     integral_sum;
  pbpid_pkg::meas_t    last_measurement;

  pbpid_pkg::dt_t      dt;
  pbpid_pkg::err_t     err;
  pbpid_pkg::err_t     delta;
  pbpid_pkg::prod_t    prod;
  pbpid_pkg::p_t       p_term;
  pbpid_pkg::isum_t    isum;
  pbpid_pkg::i_t       i_term;
  pbpid_pkg::d_t       d_term;
  pbpid_pkg::mag_t     quot;
  pbpid_pkg::rem_t     rem;
  logic                div_neg;
  pbpid_pkg::div_cnt_t div_cnt;
  pbpid_pkg::acc_t     acc;

  pbpid_pkg::mul_t     mul_a;
  pbpid_pkg::mul_t     mul_b;
  pbpid_pkg::prod_t    mul_full;
  pbpid_pkg::meas_t    meas_in;
  pbpid_pkg::err_t     err_next;
  pbpid_pkg::err_t     delta_next;
  pbpid_pkg::isum_t    lim_pos;
  pbpid_pkg::isum_t    lim_neg;
  pbpid_pkg::d_t       d_raw;
  pbpid_pkg::d_t       d_abs;
  pbpid_pkg::d_t       quot_s;
  pbpid_pkg::rem_ext_t rem_shift;
  pbpid_pkg::rem_ext_t rem_diff;
  logic                rem_ge;
  pbpid_pkg::acc_t     q_full;

  assign meas_in    = $signed(in_data.measurement);
  assign err_next   = pbpid_pkg::err_t'(meas_in) - pbpid_pkg::err_t'(target);
  assign delta_next = pbpid_pkg::err_t'(meas_in) - pbpid_pkg::err_t'(last_measurement);

  always_comb begin
    unique case (op)
      pbpid_pkg::OP_MUL_P: begin
        mul_a = pbpid_pkg::mul_t'(gain_p);
        mul_b = pbpid_pkg::mul_t'(err);
      end
      pbpid_pkg::OP_MUL_E: begin
        mul_a = pbpid_pkg::mul_t'(err);
        mul_b = pbpid_pkg::mul_t'({1'b0, dt});
      end
      pbpid_pkg::OP_MUL_I: begin
        mul_a = pbpid_pkg::mul_t'(gain_i);
        mul_b = integral_sum;
      end
      pbpid_pkg::OP_MUL_D: begin
        mul_a = pbpid_pkg::mul_t'(gain_d);
        mul_b = pbpid_pkg::mul_t'(delta);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_full = pbpid_pkg::prod_t'(mul_a) * pbpid_pkg::prod_t'(mul_b);

  assign lim_pos = $signed({2'b00, integral_limit});
  assign lim_neg = -lim_pos;

  assign d_raw  = $signed(prod[48:0]);
  assign d_abs  = d_raw[48] ? -d_raw : d_raw;
  assign quot_s = pbpid_pkg::d_t'({1'b0, quot});

  assign rem_shift = {rem, quot[47]};
  assign rem_diff  = rem_shift - {1'b0, dt};
  assign rem_ge    = (rem_shift >= {1'b0, dt});

  assign q_full = acc >>> 12;

  assign status.dt_zero  = (dt == '0);
  assign status.div_last = (div_cnt == pbpid_pkg::DIV_LAST);

  // Registers with a defined reset value; a target write clears the integral.
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p           <= '0;
      gain_i           <= '0;
      gain_d           <= '0;
      integral_limit   <= pbpid_pkg::LIMIT_RESET;
      target           <= '0;
      integral_sum     <= '0;
      last_measurement <= pbpid_pkg::LAST_RESET;
    end else begin
      if (op == pbpid_pkg::OP_LOAD) begin
        last_measurement <= meas_in;
      end
      if (op == pbpid_pkg::OP_CLAMP) begin
        if (isum > lim_pos) begin
          integral_sum <= pbpid_pkg::int_t'(lim_pos);
        end else if (isum < lim_neg) begin
          integral_sum <= pbpid_pkg::int_t'(lim_neg);
        end else begin
          integral_sum <= pbpid_pkg::int_t'(isum);
        end
      end
      if (cfg_write) begin
        unique case (cfg_index)
          pbpid_pkg::REG_GAIN_P:         gain_p         <= $signed(cfg_data);
          pbpid_pkg::REG_GAIN_I:         gain_i         <= $signed(cfg_data);
          pbpid_pkg::REG_GAIN_D:         gain_d         <= $signed(cfg_data);
          pbpid_pkg::REG_INTEGRAL_LIMIT: integral_limit <= cfg_data;
          pbpid_pkg::REG_TARGET: begin
            target       <= $signed(cfg_data[15:0]);
            integral_sum <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  // Working registers of one item.
  always_ff @(posedge clk) begin
    unique case (op)
      pbpid_pkg::OP_LOAD: begin
        dt    <= in_data.elapsed_seconds;
        err   <= err_next;
        delta <= delta_next;
      end
      pbpid_pkg::OP_MUL_P: begin
        prod <= mul_full;
      end
      pbpid_pkg::OP_MUL_E: begin
        p_term <= pbpid_pkg::p_t'(prod) + pbpid_pkg::P_OFFSET;
        prod   <= mul_full;
      end
      pbpid_pkg::OP_ADD_E: begin
        isum <= pbpid_pkg::isum_t'(integral_sum) + pbpid_pkg::isum_t'(prod);
      end
      pbpid_pkg::OP_MUL_I: begin
        prod <= mul_full;
      end
      pbpid_pkg::OP_MUL_D: begin
        if (prod > pbpid_pkg::TERM_LIMIT) begin
          i_term <= pbpid_pkg::i_t'(pbpid_pkg::TERM_LIMIT);
        end else if (prod < -pbpid_pkg::TERM_LIMIT) begin
          i_term <= pbpid_pkg::i_t'(-pbpid_pkg::TERM_LIMIT);
        end else begin
          i_term <= pbpid_pkg::i_t'(prod);
        end
        prod <= mul_full;
      end
      pbpid_pkg::OP_DIV_INIT: begin
        d_term  <= '0;
        div_neg <= d_raw[48];
        quot    <= pbpid_pkg::mag_t'(d_abs);
        rem     <= '0;
        div_cnt <= '0;
      end
      pbpid_pkg::OP_DIV_STEP: begin
        rem     <= rem_ge ? rem_diff[15:0] : rem_shift[15:0];
        quot    <= {quot[46:0], rem_ge};
        div_cnt <= div_cnt + 1'b1;
      end
      pbpid_pkg::OP_DIV_FIX: begin
        d_term <= div_neg ? -quot_s : quot_s;
      end
      pbpid_pkg::OP_SUM_PI: begin
        acc <= pbpid_pkg::acc_t'(p_term) + pbpid_pkg::acc_t'(i_term);
      end
      pbpid_pkg::OP_SUM_D: begin
        acc <= acc + pbpid_pkg::acc_t'(d_term);
      end
      pbpid_pkg::OP_OUT: begin
        if (q_full > pbpid_pkg::DRIVE_MAX) begin
          out_data.drive     <= pbpid_pkg::gain_t'(pbpid_pkg::DRIVE_MAX);
          out_data.saturated <= 1'b1;
        end else if (q_full < pbpid_pkg::DRIVE_MIN) begin
          out_data.drive     <= pbpid_pkg::gain_t'(pbpid_pkg::DRIVE_MIN);
          out_data.saturated <= 1'b1;
        end else begin
          out_data.drive     <= pbpid_pkg::gain_t'(q_full);
          out_data.saturated <= 1'b0;
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: src/proportional_band_pid_step.sv
// Top level of the proportional-band PID step with clamped integral.
// The block takes a new item only once the last result has been put on offer; the pace is set by
// the one-bit-per-cycle divider of the derivative term, skipped when elapsed_seconds is 0, and
// the single shared 33 by 33 multiplier.
// Reset is synchronous: gains and target clear, the limit goes to all ones, the integral clears
// and the last measurement becomes 2400 (150 degrees).
module proportional_band_pid_step (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  pbpid_pkg::in_item_t   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output pbpid_pkg::out_item_t  out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  pbpid_pkg::cfg_index_t cfg_index,
  input  pbpid_pkg::cfg_data_t  cfg_data
);

  pbpid_pkg::dp_op_t     op;
  pbpid_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  pbpid_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .op        (op)
  );

  pbpid_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .status    (status),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

FILE: src/pbpid_checker.sv
// Port-level assertions of the PID step and their binding to the top level.
module pbpid_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input pbpid_pkg::out_item_t out_data
);

  // A result that is not taken stays on offer unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or vanished before its transfer");

  // The block works on one item at a time.
  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an item was in progress");

  // A result never appears right after an input transfer.
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_valid && in_ready, 1) && !$past(in_valid && in_ready, 2))
    else $error("result appeared too soon after an input transfer");

  // Reset leaves no result on offer.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result on offer straight after reset");

endmodule

bind proportional_band_pid_step pbpid_checker u_pbpid_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
